>>> rtl/framed_register_protocol_slave_macros.svh
// Assertion macros used by the transmit buffer of the register protocol slave.
`ifndef FRAMED_REGISTER_PROTOCOL_SLAVE_MACROS_SVH
`define FRAMED_REGISTER_PROTOCOL_SLAVE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define FRPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frps: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define FRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frps: next-cycle check failed");

`endif

>>> rtl/frps_pkg.sv
package frps_pkg;

	// Frame byte counter
	localparam int COUNT_BITS = 9;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	// Response buffer and kept payload bytes
	localparam int RESP_DEPTH = 7;
	localparam int HEAD_DEPTH = 5;

	// Register addresses carried in the first payload byte
	localparam logic [7:0] ADDR_SPEED  = 8'h04;
	localparam logic [7:0] ADDR_TORQUE = 8'h08;

	// Length byte of each response kind
	localparam logic [7:0] RESP_ERR_LEN    = 8'h01;
	localparam logic [7:0] RESP_SET_LEN    = 8'h00;
	localparam logic [7:0] RESP_SPEED_LEN  = 8'h04;
	localparam logic [7:0] RESP_TORQUE_LEN = 8'h02;

	// Error codes on the wire
	localparam logic [7:0] ERR_SHORT       = 8'h01;
	localparam logic [7:0] ERR_LENGTH      = 8'h02;
	localparam logic [7:0] ERR_CHECKSUM    = 8'h03;
	localparam logic [7:0] ERR_UNSUPPORTED = 8'h04;
	localparam logic [7:0] ERR_INVALID_CMD = 8'h05;
	localparam logic [7:0] ERR_SET_SIZE    = 8'h06;
	localparam logic [7:0] ERR_SET_ADDR    = 8'h07;
	localparam logic [7:0] ERR_GET_SIZE    = 8'h08;
	localparam logic [7:0] ERR_GET_ADDR    = 8'h09;

	// Configuration register indexes
	localparam logic [2:0] CFG_SET_CODE  = 3'd0;
	localparam logic [2:0] CFG_GET_CODE  = 3'd1;
	localparam logic [2:0] CFG_EXEC_CODE = 3'd2;
	localparam logic [2:0] CFG_RAMP_CODE = 3'd3;
	localparam logic [2:0] CFG_ACK_BYTE  = 3'd4;
	localparam logic [2:0] CFG_NACK_BYTE = 3'd5;

	// Whole response handed to the transmit buffer
	typedef struct packed {
		logic                         valid;
		logic [2:0]                   len;
		logic [RESP_DEPTH-1:0][7:0]   bytes;
	} resp_load_t;

	// Fold a 16-bit sum: low byte plus high byte, mod 256
	function automatic logic [7:0] fold16(input logic [15:0] s);
		fold16 = s[7:0] + s[15:8];
	endfunction

	// Checksum of the first n response bytes
	function automatic logic [7:0] resp_sum(input logic [5:0][7:0] b, input logic [2:0] n);
		logic [10:0] s;
		s = '0;
		for (int i = 0; i < 6; i++) begin
			if (3'(i) < n) begin
				s = s + {3'b000, b[i]};
			end
		end
		resp_sum = s[7:0] + {5'b00000, s[10:8]};
	endfunction

endpackage

>>> rtl/frps_tx_buffer.sv
`include "framed_register_protocol_slave_macros.svh"

module frps_tx_buffer (
	input  logic                clk,
	input  logic                arst_n,
	input  frps_pkg::resp_load_t load,
	output logic                empty,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          tx_byte,
	output logic                tx_last
);
	import frps_pkg::*;

	logic [RESP_DEPTH-1:0][7:0] buf_q;
	logic [2:0]                 cnt_q;
	logic                       pop;

	assign empty     = (cnt_q == 3'd0);
	assign out_valid = !empty;
	assign tx_byte   = buf_q[0];
	assign tx_last   = (cnt_q == 3'd1);
	assign pop       = out_valid && !out_stall;

	// Hold the byte count; load a whole response, drop one byte per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load.valid) begin
			cnt_q <= load.len;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// Shift response bytes toward the output
	always_ff @(posedge clk) begin
		if (load.valid) begin
			buf_q <= load.bytes;
		end else if (pop) begin
			for (int i = 0; i < RESP_DEPTH - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

	`FRPS_ASSERT_SAME(a_load_when_empty, clk, arst_n, load.valid, empty)
	`FRPS_ASSERT_NEXT(a_load_len, clk, arst_n, load.valid,
		cnt_q == 3'd3 || cnt_q == 3'd4 || cnt_q == 3'd5 || cnt_q == 3'd7)
	`FRPS_ASSERT_NEXT(a_last_drains, clk, arst_n, pop && tx_last, empty)

endmodule

>>> rtl/framed_register_protocol_slave.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+------------------
// request   | in        | in_valid / in_stall  | rx_byte, frame_end
// response  | out       | out_valid / out_stall| tx_byte, tx_last
// config    | in        | cfg_we               | cfg_index, cfg_data
//
// A request byte is held in the input register and then taken in;
// bytes that do not end a frame flow at one per cycle.
// The end byte builds the whole response (3, 4, 5 or 7 bytes) combinationally
// and loads it into the transmit buffer, which then sends one byte per cycle
// while out_stall is low.
// A frame end waits in the input register while the buffer still holds an
// earlier response; in_stall rises only then. Reset clears frame state and
// stored values, restores the default configuration and empties both stages.
module framed_register_protocol_slave (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       frame_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] tx_byte,
	output logic       tx_last,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import frps_pkg::*;

	// Configuration
	logic [4:0] set_code_q, get_code_q, exec_code_q, ramp_code_q;
	logic [7:0] ack_q, nack_q;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// Frame state and stored values
	logic [COUNT_BITS-1:0] count_q;
	logic [7:0]            first_q;
	logic [7:0]            len_q;
	logic [15:0]           sum_q;
	logic [7:0]            head_q [HEAD_DEPTH];
	logic [31:0]           speed_q;
	logic [15:0]           torque_q;

	logic                  tx_empty;
	logic                  consume;
	logic                  accept;
	resp_load_t            load;

	logic [COUNT_BITS-1:0] n_cnt, psize;
	logic [7:0]            len3;
	logic [4:0]            cmd;
	logic                  err;
	logic [7:0]            ecode;
	logic                  set_spd, set_trq, get_spd, get_trq;
	logic [RESP_DEPTH-1:0][7:0] r;
	logic [2:0]            rn;
	logic [2:0]            hidx;
	logic                  head_we;

	assign consume  = valid_s1 && (!end_s1 || tx_empty);
	assign in_stall = valid_s1 && !consume;
	assign accept   = in_valid && !in_stall;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_code_q  <= 5'd1;
			get_code_q  <= 5'd2;
			exec_code_q <= 5'd3;
			ramp_code_q <= 5'd4;
			ack_q       <= 8'h06;
			nack_q      <= 8'h15;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_CODE:  set_code_q  <= cfg_data[4:0];
				CFG_GET_CODE:  get_code_q  <= cfg_data[4:0];
				CFG_EXEC_CODE: exec_code_q <= cfg_data[4:0];
				CFG_RAMP_CODE: ramp_code_q <= cfg_data[4:0];
				CFG_ACK_BYTE:  ack_q       <= cfg_data;
				CFG_NACK_BYTE: nack_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
			end_s1  <= frame_end;
		end
	end

	// Decode the frame at its end byte and build the response
	always_comb begin
		n_cnt   = (count_q == CNT_MAX) ? count_q : count_q + 1'b1;
		psize   = n_cnt - COUNT_BITS'(3);
		len3    = len_q + 8'd3;
		cmd     = first_q[4:0];
		hidx    = count_q[2:0] - 3'd2;
		head_we = (count_q >= COUNT_BITS'(2)) && (count_q < COUNT_BITS'(HEAD_DEPTH + 2));
		err     = 1'b0;
		ecode   = ERR_SHORT;
		set_spd = 1'b0;
		set_trq = 1'b0;
		get_spd = 1'b0;
		get_trq = 1'b0;
		if (n_cnt < COUNT_BITS'(4)) begin
			err   = 1'b1;
			ecode = ERR_SHORT;
		end else if (n_cnt == CNT_MAX ||
				n_cnt != {{(COUNT_BITS-8){1'b0}}, len3}) begin
			err   = 1'b1;
			ecode = ERR_LENGTH;
		end else if (byte_s1 != fold16(sum_q)) begin
			err   = 1'b1;
			ecode = ERR_CHECKSUM;
		end else if (cmd == set_code_q) begin
			if (psize < COUNT_BITS'(3)) begin
				err   = 1'b1;
				ecode = ERR_SET_SIZE;
			end else if (head_q[0] == ADDR_SPEED) begin
				if (psize != COUNT_BITS'(5)) begin
					err   = 1'b1;
					ecode = ERR_SET_SIZE;
				end else begin
					set_spd = 1'b1;
				end
			end else if (head_q[0] == ADDR_TORQUE) begin
				if (psize != COUNT_BITS'(3)) begin
					err   = 1'b1;
					ecode = ERR_SET_SIZE;
				end else begin
					set_trq = 1'b1;
				end
			end else begin
				err   = 1'b1;
				ecode = ERR_SET_ADDR;
			end
		end else if (cmd == get_code_q) begin
			if (psize != COUNT_BITS'(1)) begin
				err   = 1'b1;
				ecode = ERR_GET_SIZE;
			end else if (head_q[0] == ADDR_SPEED) begin
				get_spd = 1'b1;
			end else if (head_q[0] == ADDR_TORQUE) begin
				get_trq = 1'b1;
			end else begin
				err   = 1'b1;
				ecode = ERR_GET_ADDR;
			end
		end else if (cmd == exec_code_q || cmd == ramp_code_q) begin
			err   = 1'b1;
			ecode = ERR_UNSUPPORTED;
		end else begin
			err   = 1'b1;
			ecode = ERR_INVALID_CMD;
		end

		// Assemble response bytes ahead of the checksum
		r = '0;
		if (err) begin
			r[0] = nack_q;
			r[1] = RESP_ERR_LEN;
			r[2] = ecode;
			rn   = 3'd3;
		end else if (set_spd || set_trq) begin
			r[0] = ack_q;
			r[1] = RESP_SET_LEN;
			rn   = 3'd2;
		end else if (get_spd) begin
			r[0] = ack_q;
			r[1] = RESP_SPEED_LEN;
			r[2] = speed_q[7:0];
			r[3] = speed_q[15:8];
			r[4] = speed_q[23:16];
			r[5] = speed_q[31:24];
			rn   = 3'd6;
		end else begin
			r[0] = ack_q;
			r[1] = RESP_TORQUE_LEN;
			r[2] = torque_q[7:0];
			r[3] = torque_q[15:8];
			rn   = 3'd4;
		end
		r[rn] = resp_sum(r[5:0], rn);

		load.valid = consume && end_s1;
		load.len   = rn + 3'd1;
		load.bytes = r;
	end

	// Advance frame state; clear it at every frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			first_q <= '0;
			len_q   <= '0;
			sum_q   <= '0;
		end else if (consume) begin
			if (end_s1) begin
				count_q <= '0;
				first_q <= '0;
				len_q   <= '0;
				sum_q   <= '0;
			end else begin
				count_q <= n_cnt;
				sum_q   <= sum_q + {8'h00, byte_s1};
				if (count_q == COUNT_BITS'(0)) begin
					first_q <= byte_s1;
				end
				if (count_q == COUNT_BITS'(1)) begin
					len_q <= byte_s1;
				end
			end
		end
	end

	// Keep the first payload bytes
	always_ff @(posedge clk) begin
		if (consume && !end_s1 && head_we) begin
			head_q[hidx] <= byte_s1;
		end
	end

	// Update stored values on SET and after GET
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q  <= '0;
			torque_q <= '0;
		end else if (load.valid) begin
			if (set_spd) begin
				speed_q <= {head_q[4], head_q[3], head_q[2], head_q[1]};
			end else if (get_spd) begin
				speed_q <= speed_q + 32'd1;
			end
			if (set_trq) begin
				torque_q <= {head_q[2], head_q[1]};
			end else if (get_trq) begin
				torque_q <= torque_q + 16'd1;
			end
		end
	end

	frps_tx_buffer u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.empty     (tx_empty),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tx_byte   (tx_byte),
		.tx_last   (tx_last)
	);

endmodule
